/* rtl/bpa_pkg.sv */
// shared constants and types for the buddy page allocator
package bpa_pkg;

    localparam int PAGE_COUNT = 1024;
    localparam int TOP_ORDER  = 10;
    localparam int PAGE_BYTES = 4096;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(PAGE_COUNT);
    localparam int ORD_W      = 4;
    localparam int CNT_W      = ((IDX_W > TOP_ORDER) ? IDX_W : TOP_ORDER) + 2;

    localparam logic [63:0] POOL_BYTES = 64'(PAGE_COUNT) * 64'(PAGE_BYTES);
    localparam logic [31:0] RESET_BASE = 32'h0090_0000;

    // descriptor word: {first, occupied, order}
    localparam int DESC_W = ORD_W + 2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic             bad_size;
        logic [ORD_W-1:0] want;
        logic             bad_addr;
        logic [IDX_W-1:0] page;
    } t_req_info;

endpackage

/* rtl/bpa_ram.sv */
// descriptor memory with per-bit write enables and registered read
module bpa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic [WIDTH-1:0]         i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // masked write
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < WIDTH; b++) begin
            if (i_we[b]) begin
                mem[i_waddr][b] <= i_wdata[b];
            end
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bpa_decode.sv */
// request decode: size to order, free address to page index
module bpa_decode
    import bpa_pkg::*;
(
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_block_address,
    input  logic [31:0] i_base,
    output t_req_info   o_info
);

    logic [63:0] size_w;
    logic [63:0] off_w;
    logic [ORD_W-1:0] want;
    logic found;

    assign size_w = {32'd0, i_size_bytes};
    assign off_w  = {32'd0, i_block_address} - {32'd0, i_base};

    // smallest order whose span covers the size
    always_comb begin
        want  = '0;
        found = 1'b0;
        for (int k = TOP_ORDER; k >= 0; k--) begin
            if (size_w <= (64'(PAGE_BYTES) << k)) begin
                want  = ORD_W'(k);
                found = 1'b1;
            end
        end
    end

    assign o_info.bad_size = (i_size_bytes == 32'd0) || (size_w > POOL_BYTES) || !found;
    assign o_info.want     = want;
    assign o_info.bad_addr = (i_block_address < i_base) || (off_w >= POOL_BYTES);
    assign o_info.page     = off_w[PAGE_SHIFT +: IDX_W];

endmodule

/* rtl/buddy_page_allocator_core.sv */
// buddy page allocator top level: request sequencer over the descriptor memory
// allocate scans the descriptors for a fit, then marks each page of the granted block,
//   or of the whole block when it is split; free clears each page released, rewrites
//   each page of the merged block for every merge, and ends on a last buddy check;
//   the result then goes to the output beat
// throughput: one request at a time, bound by the single descriptor memory
// reset: synchronous; a clearing pass over every descriptor precedes the first request; base 0x900000
module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // size_bytes[31:0], block_address[63:32]
    input  logic        i_s_tuser,   // func
    // response channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // granted_address[31:0], status[33:32], zero pad
    // pool base register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_MARK,
        S_F_RD, S_F_EV, S_F_SWEEP, S_M_CHK, S_M_EV, S_M_SWEEP, S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_best, n_best;
    logic [ORD_W-1:0] r_best_ord, n_best_ord;
    logic             r_have_best, n_have_best;
    logic             r_split, n_split;
    logic [ORD_W-1:0] r_want, n_want;
    logic [ORD_W-1:0] r_ord, n_ord;
    logic [CNT_W-1:0] r_wptr, n_wptr;
    logic [CNT_W-1:0] r_wend, n_wend;
    logic [1:0]       r_status, n_status;
    logic [31:0]      r_base;
    logic             r_ovalid;
    logic [31:0]      r_oaddr;
    logic [1:0]       r_ostat;
    logic             r_func_alloc;

    t_req_info        req;
    logic [DESC_W-1:0] ram_we, ram_wdata, ram_rdata;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [ORD_W-1:0]  rd_order;
    logic              rd_occ, rd_first;
    logic              out_free;

    logic [CNT_W-1:0] d_off;
    logic [ORD_W-1:0] d_msb;
    logic [CNT_W-1:0] span_rd, span_best, span_want, span_ord;
    logic [CNT_W-1:0] buddy, left_idx;
    logic [CNT_W-1:0] mark_end;

    bpa_decode u_decode (
        .i_size_bytes   (i_s_tdata[31:0]),
        .i_block_address(i_s_tdata[63:32]),
        .i_base         (r_base),
        .o_info         (req)
    );

    bpa_ram #(.WIDTH(DESC_W), .DEPTH(PAGE_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_order = ram_rdata[ORD_W-1:0];
    assign rd_occ   = ram_rdata[ORD_W];
    assign rd_first = ram_rdata[ORD_W+1];

    // block spans
    assign span_rd   = CNT_W'(1) << rd_order;
    assign span_best = CNT_W'(1) << r_best_ord;
    assign span_want = CNT_W'(1) << r_want;
    assign span_ord  = CNT_W'(1) << r_ord;
    assign buddy     = r_idx ^ span_ord;
    assign left_idx  = r_idx & ~span_ord;

    // offset inside the marked block and its leading one
    assign d_off = r_wptr - {{(CNT_W-IDX_W){1'b0}}, r_best};
    always_comb begin
        d_msb = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (d_off[b]) begin
                d_msb = ORD_W'(b);
            end
        end
    end

    assign out_free    = !r_ovalid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {6'd0, r_ostat, r_oaddr};

    // memory access per state
    always_comb begin
        ram_we    = '0;
        ram_waddr = r_wptr[IDX_W-1:0];
        ram_wdata = '0;
        ram_raddr = r_idx[IDX_W-1:0];
        case (r_state)
            S_CLEAR: begin
                ram_we    = '1;
                ram_wdata = {1'b0, 1'b0, ORD_W'(TOP_ORDER)};
            end
            S_MARK: begin
                ram_we[ORD_W-1:0] = {ORD_W{r_split}};
                ram_we[ORD_W]     = (d_off < span_want);
                ram_we[ORD_W+1]   = (d_off == '0);
                ram_wdata = {1'b1, 1'b1, (d_off < span_want) ? r_want : d_msb};
            end
            S_F_SWEEP: begin
                ram_we[ORD_W]   = 1'b1;
                ram_we[ORD_W+1] = (r_wptr == r_idx);
                ram_wdata       = '0;
            end
            S_M_SWEEP: begin
                ram_we[ORD_W-1:0] = '1;
                ram_wdata = {1'b0, 1'b0, r_ord};
            end
            S_M_CHK: begin
                ram_raddr = buddy[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // clipped end of the block to mark
    always_comb begin
        logic [CNT_W-1:0] e;
        e = {{(CNT_W-IDX_W){1'b0}}, r_best} + (r_split ? span_best : span_want);
        mark_end = (e > CNT_W'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT) : e;
    end

    // sequencer next state
    always_comb begin
        logic [CNT_W-1:0] e;
        n_state     = r_state;
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_ord  = r_best_ord;
        n_have_best = r_have_best;
        n_split     = r_split;
        n_want      = r_want;
        n_ord       = r_ord;
        n_wptr      = r_wptr;
        n_wend      = r_wend;
        n_status    = r_status;
        e           = '0;
        case (r_state)
            S_CLEAR: begin
                n_wptr = r_wptr + 1'b1;
                if (r_wptr == CNT_W'(PAGE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser == FUNC_ALLOC) begin
                        n_want      = req.want;
                        n_idx       = '0;
                        n_have_best = 1'b0;
                        if (req.bad_size) begin
                            n_status = ST_BAD_SIZE;
                            n_state  = S_FINISH;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        n_idx = {{(CNT_W-IDX_W){1'b0}}, req.page};
                        if (req.bad_addr) begin
                            n_status = ST_BAD_ADDR;
                            n_state  = S_FINISH;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= CNT_W'(PAGE_COUNT)) begin
                    if (!r_have_best) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_FINISH;
                    end else begin
                        n_split = 1'b1;
                        n_wptr  = {{(CNT_W-IDX_W){1'b0}}, r_best};
                        n_state = S_MARK;
                    end
                end else begin
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (rd_order == r_want && !rd_occ) begin
                    n_best  = r_idx[IDX_W-1:0];
                    n_split = 1'b0;
                    n_wptr  = r_idx;
                    n_state = S_MARK;
                end else if (rd_order <= r_want) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    if (!rd_occ && (!r_have_best || r_best_ord > rd_order)) begin
                        n_best      = r_idx[IDX_W-1:0];
                        n_best_ord  = rd_order;
                        n_have_best = 1'b1;
                    end
                    n_idx   = r_idx + span_rd;
                    n_state = S_SCAN_RD;
                end
            end
            S_MARK: begin
                n_wptr = r_wptr + 1'b1;
                if (r_wptr + 1'b1 >= mark_end) begin
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                end
            end
            S_F_RD: begin
                n_state = S_F_EV;
            end
            S_F_EV: begin
                if (!rd_first) begin
                    n_status = ST_BAD_ADDR;
                    n_state  = S_FINISH;
                end else begin
                    n_ord  = rd_order;
                    n_wptr = r_idx;
                    e      = r_idx + span_rd;
                    n_wend = (e > CNT_W'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT) : e;
                    n_state = S_F_SWEEP;
                end
            end
            S_F_SWEEP, S_M_SWEEP: begin
                n_wptr = r_wptr + 1'b1;
                if (r_wptr + 1'b1 >= r_wend) begin
                    n_state = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (r_ord >= ORD_W'(TOP_ORDER) || buddy >= CNT_W'(PAGE_COUNT)) begin
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                end else begin
                    n_state = S_M_EV;
                end
            end
            S_M_EV: begin
                if (rd_occ || rd_order != r_ord) begin
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                end else begin
                    n_ord   = r_ord + 1'b1;
                    n_idx   = left_idx;
                    n_wptr  = left_idx;
                    e       = left_idx + (span_ord << 1);
                    n_wend  = (e > CNT_W'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT) : e;
                    n_state = S_M_SWEEP;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wptr      <= '0;
            r_have_best <= 1'b0;
            r_ovalid    <= 1'b0;
            r_base      <= RESET_BASE;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_have_best <= n_have_best;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (r_state == S_FINISH && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_best_ord <= n_best_ord;
        r_split    <= n_split;
        r_want     <= n_want;
        r_ord      <= n_ord;
        r_wend     <= n_wend;
        r_status   <= n_status;
        if (r_state == S_FINISH && out_free) begin
            r_ostat <= r_status;
            if (r_status == ST_OK && r_func_alloc) begin
                r_oaddr <= r_base + 32'({r_best, {PAGE_SHIFT{1'b0}}});
            end else begin
                r_oaddr <= '0;
            end
        end
    end

    // kind of the request in flight
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_func_alloc <= (i_s_tuser == FUNC_ALLOC);
        end
    end

endmodule
